// ===== rtl/me_pkg.sv =====
`default_nettype none
package me_pkg;

   // Field widths of the item and result words.
   localparam int BASE_W = 64;
   localparam int EXP_W = 63;
   localparam int VAL_W = 63;

   // Default number of exponent bits that are scanned.
   localparam int DEFAULT_WIDTH = 64;

   // Depth of the queue between the front and the back; a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Steps of the bit-serial multiplier and of the base reduction.
   localparam int MUL_STEPS = VAL_W;
   localparam int MCNT_W = $clog2(MUL_STEPS);
   localparam int RED_STEPS = BASE_W;
   localparam int RCNT_W = $clog2(RED_STEPS);

   // One classified item as it waits in the queue.
   typedef struct packed {
      logic zero_mod;
      logic [BASE_W-1:0] base_value;
      logic [EXP_W-1:0] exponent;
      logic [VAL_W-1:0] modulus;
   } item_type;

endpackage
`default_nettype wire

// ===== rtl/modular_exponentiation.sv =====
`default_nettype none
// Computes base^exponent mod modulus by right-to-left square-and-multiply. Words are
// queued (two deep) by the front and worked one at a time by the back. A word first
// reduces its signed base modulo the modulus, then for each exponent bit up to the
// highest one bit it runs a squaring and, on a one bit, a multiplication first; each
// runs on one shared bit-serial modular multiplier. A zero exponent or zero modulus
// skips all of this. A zero modulus yields 0, and otherwise a zero exponent yields 1.
// Only the low WIDTH exponent bits are used.
module modular_exponentiation #(
   parameter int WIDTH = me_pkg::DEFAULT_WIDTH
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [me_pkg::BASE_W-1:0] req_base_value,
   input wire logic [me_pkg::EXP_W-1:0] req_exponent,
   input wire logic [me_pkg::VAL_W-1:0] req_modulus,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [me_pkg::VAL_W-1:0] rsp_power_result
);

   logic q_valid, q_pop;
   me_pkg::item_type q_item;

   // Front: accepts and classifies words into the queue.
   me_front #(.WIDTH(WIDTH)) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_base_value(req_base_value),
      .req_exponent(req_exponent),
      .req_modulus(req_modulus),
      .q_valid(q_valid),
      .q_pop(q_pop),
      .q_item(q_item)
   );

   // Back: reduction and exponentiation with its own output register.
   me_engine u_engine (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_pop(q_pop),
      .q_item(q_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_power_result(rsp_power_result)
   );

endmodule
`default_nettype wire

// ===== rtl/me_front.sv =====
`default_nettype none
module me_front #(
   parameter int WIDTH = me_pkg::DEFAULT_WIDTH
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [me_pkg::BASE_W-1:0] req_base_value,
   input wire logic [me_pkg::EXP_W-1:0] req_exponent,
   input wire logic [me_pkg::VAL_W-1:0] req_modulus,
   output logic q_valid,
   input wire logic q_pop,
   output me_pkg::item_type q_item
);

   // Exponent bits at or above WIDTH are never scanned.
   localparam logic [me_pkg::EXP_W-1:0] EXP_MASK = (WIDTH >= me_pkg::EXP_W) ? '1 :
      me_pkg::EXP_W'((64'd1 << WIDTH) - 64'd1);

   me_pkg::item_type q_ff [me_pkg::QUEUE_DEPTH];
   logic [me_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [me_pkg::QCNT_W-1:0] count_ff, count_in;
   logic push, pop;
   me_pkg::item_type new_item;

   // Classify the incoming word.
   always_comb begin
      new_item.zero_mod = (req_modulus == '0);
      new_item.base_value = req_base_value;
      new_item.exponent = req_exponent & EXP_MASK;
      new_item.modulus = req_modulus;
   end

   assign req_stall = (count_ff == me_pkg::QCNT_W'(me_pkg::QUEUE_DEPTH));
   assign push = req_valid && !req_stall;
   assign q_valid = (count_ff != '0);
   assign pop = q_pop && q_valid;
   assign q_item = q_ff[rd_ptr_ff];

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Queue entries.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/me_mulmod.sv =====
`default_nettype none
module me_mulmod (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic [me_pkg::VAL_W-1:0] op_a,
   input wire logic [me_pkg::VAL_W-1:0] op_b,
   input wire logic [me_pkg::VAL_W-1:0] op_m,
   output logic done,
   output logic [me_pkg::VAL_W-1:0] product
);

   localparam int W = me_pkg::VAL_W;

   logic [W-1:0] a_ff, a_in, b_ff, m_ff, acc_ff, acc_in;
   logic [me_pkg::MCNT_W-1:0] cnt_ff, cnt_in;
   logic phase_ff, phase_in, busy_ff, busy_in, done_ff, done_in;
   logic [W:0] dbl, dbl_red, sum, sum_red;

   // Doubling and adding each take one compare and subtract in their own cycle.
   always_comb begin
      dbl = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
      sum = {1'b0, acc_ff} + {1'b0, b_ff};
      sum_red = (sum >= {1'b0, m_ff}) ? sum - {1'b0, m_ff} : sum;
   end

   // A doubling step and then an add step per multiplier bit, most significant bit first.
   always_comb begin
      a_in = a_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      phase_in = phase_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in = op_a;
         acc_in = '0;
         cnt_in = '0;
         phase_in = 1'b0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            acc_in = dbl_red[W-1:0];
            phase_in = 1'b1;
         end else begin
            if (a_ff[W-1]) begin
               acc_in = sum_red[W-1:0];
            end
            a_in = {a_ff[W-2:0], 1'b0};
            phase_in = 1'b0;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == me_pkg::MCNT_W'(me_pkg::MUL_STEPS - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         phase_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         phase_ff <= phase_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      acc_ff <= acc_in;
      if (start) begin
         b_ff <= op_b;
         m_ff <= op_m;
      end
   end

   assign done = done_ff;
   assign product = acc_ff;

endmodule
`default_nettype wire

// ===== rtl/me_engine.sv =====
`default_nettype none
module me_engine (
   input wire logic clock,
   input wire logic reset,
   input wire logic q_valid,
   output logic q_pop,
   input wire me_pkg::item_type q_item,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [me_pkg::VAL_W-1:0] rsp_power_result
);

   localparam int W = me_pkg::VAL_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RED = 3'd1;
   localparam logic [2:0] S_FIX = 3'd2;
   localparam logic [2:0] S_STEP = 3'd3;
   localparam logic [2:0] S_MULR = 3'd4;
   localparam logic [2:0] S_SQ = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [me_pkg::BASE_W-1:0] mag_ff, mag_in;
   logic neg_ff, neg_in;
   logic [W-1:0] rem_ff, rem_in, m_ff, m_in, pw_ff, pw_in, res_ff, res_in;
   logic [me_pkg::EXP_W-1:0] exp_ff, exp_in;
   logic [me_pkg::RCNT_W-1:0] rcnt_ff, rcnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_data_ff, rsp_data_in;
   logic [W:0] rshift, rshift_red;
   logic mul_start, mul_done;
   logic [W-1:0] mul_a, mul_p;
   logic out_free;

   me_mulmod u_mulmod (
      .clock(clock),
      .reset(reset),
      .start(mul_start),
      .op_a(mul_a),
      .op_b(pw_ff),
      .op_m(m_ff),
      .done(mul_done),
      .product(mul_p)
   );

   // One restoring remainder step of the base reduction.
   always_comb begin
      rshift = {rem_ff, mag_ff[me_pkg::BASE_W-1]};
      rshift_red = (rshift >= {1'b0, m_ff}) ? rshift - {1'b0, m_ff} : rshift;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer over reduction, multiply and square.
   always_comb begin
      state_in = state_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      rem_in = rem_ff;
      m_in = m_ff;
      pw_in = pw_ff;
      res_in = res_ff;
      exp_in = exp_ff;
      rcnt_in = rcnt_ff;
      q_pop = 1'b0;
      mul_start = 1'b0;
      mul_a = pw_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               m_in = q_item.modulus;
               exp_in = q_item.exponent;
               neg_in = q_item.base_value[me_pkg::BASE_W-1];
               mag_in = q_item.base_value[me_pkg::BASE_W-1] ?
                  (~q_item.base_value) + 1'b1 : q_item.base_value;
               rem_in = '0;
               rcnt_in = '0;
               if (q_item.zero_mod) begin
                  res_in = '0;
                  state_in = S_DONE;
               end else if (q_item.exponent == '0) begin
                  res_in = W'(1);
                  state_in = S_DONE;
               end else begin
                  state_in = S_RED;
               end
            end
         end
         S_RED: begin
            rem_in = rshift_red[W-1:0];
            mag_in = {mag_ff[me_pkg::BASE_W-2:0], 1'b0};
            rcnt_in = rcnt_ff + 1'b1;
            if (rcnt_ff == me_pkg::RCNT_W'(me_pkg::RED_STEPS - 1)) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            // A negative base takes the non-negative remainder.
            pw_in = (neg_ff && rem_ff != '0) ? m_ff - rem_ff : rem_ff;
            res_in = W'(1);
            state_in = S_STEP;
         end
         S_STEP: begin
            if (exp_ff == '0) begin
               state_in = S_DONE;
            end else begin
               mul_start = 1'b1;
               if (exp_ff[0]) begin
                  mul_a = res_ff;
                  state_in = S_MULR;
               end else begin
                  state_in = S_SQ;
               end
            end
         end
         S_MULR: begin
            if (mul_done) begin
               res_in = mul_p;
               mul_start = 1'b1;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (mul_done) begin
               pw_in = mul_p;
               exp_in = exp_ff >> 1;
               state_in = S_STEP;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      m_ff <= m_in;
      pw_ff <= pw_in;
      res_ff <= res_in;
      exp_ff <= exp_in;
      rcnt_ff <= rcnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_power_result = rsp_data_ff;

endmodule
`default_nettype wire

// ===== rtl/me_checker.sv =====
`default_nettype none
module me_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic [me_pkg::VAL_W-1:0] rsp_power_result
);

   logic [2:0] open_ff, open_in;
   logic acc_in_w, acc_out_w;

   assign acc_in_w = req_valid && !req_stall;
   assign acc_out_w = rsp_valid && !rsp_stall;

   // Words accepted whose result has not yet been taken.
   always_comb begin
      open_in = open_ff + {2'b00, acc_in_w} - {2'b00, acc_out_w};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_power_result))
      else $error("stalled result word changed");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 3'd0)
      else $error("result word without an accepted input word");

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> open_ff != 3'd0)
      else $error("input stalled while nothing is outstanding");

   a_bound: assert property (@(posedge clock) disable iff (reset)
      open_ff <= 3'd4)
      else $error("more words outstanding than the block can hold");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word shown right after reset");

endmodule

bind modular_exponentiation me_checker u_me_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_power_result(rsp_power_result)
);
`default_nettype wire
